// File: rtl/lru_cache_hit_simulator_defines.svh
// Assertion macros shared by the cache simulator RTL.
`ifndef LRU_CACHE_HIT_SIMULATOR_DEFINES_SVH
`define LRU_CACHE_HIT_SIMULATOR_DEFINES_SVH
`ifndef SYNTH
`define LCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LCS_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LCS_ASSERT(label, clk, rst_n, prop)
`define LCS_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: rtl/lcs_pkg.sv
// Package with constants and types of the cache simulator.
package lcs_pkg;
  localparam int unsigned MaxLines = 256;
  localparam int unsigned SlotW = $clog2(MaxLines);
  localparam int unsigned CapW = SlotW + 1;
  localparam int unsigned SectorW = 48;
  localparam int unsigned CountW = 20;
  localparam int unsigned SectorsPerLine = 8;
  localparam int unsigned OffW = $clog2(SectorsPerLine);
  localparam int unsigned TagW = SectorW - OffW;
  localparam int unsigned TotW = 48;
  localparam int unsigned PctW = 7;
  localparam logic [TotW-1:0] TotMax = '1;
  localparam logic [1:0] ReqRead = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
endpackage

// File: rtl/lcs_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
module lcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/lcs_div.sv
// Restoring divider for the hit percentage, one quotient bit per cycle.
module lcs_div
  import lcs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [TotW-1:0] hits_i,
  input  logic [TotW-1:0] reqs_i,
  output logic            done_o,
  output logic [PctW-1:0] pct_o
);
  localparam int unsigned NumW = TotW + PctW;
  localparam int unsigned StepW = $clog2(NumW + 1);
  logic [NumW-1:0] num_q, num_d;
  logic [TotW:0] rem_q, rem_d;
  logic [TotW-1:0] den_q, den_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [TotW:0] sh;
  logic [NumW-1:0] prod;
  assign prod = NumW'(hits_i) * NumW'(100);
  assign sh = {rem_q[TotW-1:0], num_q[NumW-1]};
  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = prod; rem_d = '0; den_d = reqs_i; cnt_d = StepW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
  end
  assign done_o = done_q;
  assign pct_o = num_q[PctW-1:0];
endmodule

// File: rtl/lru_cache_hit_simulator.sv
// Top level of the fully associative LRU cache hit simulator.
// Usage: raise start with a request on has_io_i, req_type_i, start_sector_i
// and sector_count_i; it is taken at a clock edge where busy is low. One
// result beat follows per request, shown for one cycle with result_strobe_o;
// the receiver cannot stall it. An invalid request gives a cleared beat,
// passing from S_SETUP straight to S_OUT. A valid request walks its covered
// lines one at a time: each line scans the tag memory slot by slot, reading
// in S_SCAN and comparing in S_CHK, stopping at a hit and covering all 256
// slots on a miss, then updates the recency links and does any eviction.
// A 55-step divide for the percentage follows the line walk, then the beat.
// busy stays high until the beat, so requests never overlap.
// The line capacity is written through cfg_valid_i/cfg_ready_o while idle;
// lowering it evicts the oldest lines via S_SETUP, S_EVR and S_EVL while busy.
// Reset clears the valid bits, counters and pointers at once, no sweep;
// capacity returns to 256.
module lru_cache_hit_simulator
  import lcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               has_io_i,
  input  logic [1:0]         req_type_i,
  input  logic [SectorW-1:0] start_sector_i,
  input  logic [CountW-1:0]  sector_count_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CapW-1:0]    cfg_data_i,
  output logic               result_strobe_o,
  output logic               result_valid_o,
  output logic               hit_o,
  output logic [PctW-1:0]    hit_percent_o
);
`include "lru_cache_hit_simulator_defines.svh"
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SETUP = 12'b000000000010,
    S_SCAN  = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_MOVE  = 12'b000000010000,
    S_RDL   = 12'b000000100000,
    S_LNK   = 12'b000001000000,
    S_EVR   = 12'b000010000000,
    S_EVL   = 12'b000100000000,
    S_INS   = 12'b001000000000,
    S_DIV   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;
  // S_MOVE/S_EVR issue reads of the slot links; S_RDL/S_EVL use them.
  state_e st_q, st_d;
  logic [MaxLines-1:0] vld_q, vld_d;
  logic [SlotW-1:0] old_q, old_d, new_q, new_d, slot_q, slot_d, scan_q, scan_d;
  logic [CapW-1:0] occ_q, occ_d, cap_q, cap_d;
  logic [TotW-1:0] req_q, req_d, hits_q, hits_d;
  logic [TagW-1:0] line_q, line_d, last_q, last_d;
  logic hit_q, hit_d, ok_q, ok_d, evict_only_q, evict_only_d, found_q, found_d;
  logic [PctW-1:0] pct_q, pct_d;
  logic strobe_q, strobe_d;
  logic div_start, div_done;
  logic [PctW-1:0] div_pct;
  // Memories.
  logic tag_we, nl_we, ol_we;
  logic [SlotW-1:0] tag_wa, nl_wa, ol_wa, tag_ra, nl_ra, ol_ra;
  logic [TagW-1:0] tag_wd, tag_rd;
  logic [SlotW-1:0] nl_wd, ol_wd, nl_rd, ol_rd;
  lcs_ram #(.Width(TagW), .Depth(MaxLines)) u_tag (.clk_i, .we_i(tag_we),
    .waddr_i(tag_wa), .wdata_i(tag_wd), .raddr_i(tag_ra), .rdata_o(tag_rd));
  lcs_ram #(.Width(SlotW), .Depth(MaxLines)) u_nl (.clk_i, .we_i(nl_we),
    .waddr_i(nl_wa), .wdata_i(nl_wd), .raddr_i(nl_ra), .rdata_o(nl_rd));
  lcs_ram #(.Width(SlotW), .Depth(MaxLines)) u_ol (.clk_i, .we_i(ol_we),
    .waddr_i(ol_wa), .wdata_i(ol_wd), .raddr_i(ol_ra), .rdata_o(ol_rd));
  lcs_div u_div (.clk_i, .rst_ni, .start_i(div_start), .hits_i(hits_q),
    .reqs_i(req_q), .done_o(div_done), .pct_o(div_pct));

  logic [CapW-1:0] eff_cap;
  logic [SectorW:0] end_full;
  logic [SectorW-1:0] end_sec;
  logic [TagW-1:0] first_ln, last_ln, span_m1;
  logic [SlotW-1:0] free_slot;
  logic free_any;
  logic accept;
  assign eff_cap = (cap_q == '0) ? CapW'(1) :
                   ((cap_q > CapW'(MaxLines)) ? CapW'(MaxLines) : cap_q);
  assign end_full = {1'b0, start_sector_i} + (SectorW+1)'(sector_count_i) - 1'b1;
  assign end_sec = end_full[SectorW] ? '1 : end_full[SectorW-1:0];
  assign first_ln = start_sector_i[SectorW-1:OffW];
  assign last_ln = end_sec[SectorW-1:OffW];
  assign span_m1 = last_ln - first_ln;
  assign accept = start && !busy;
  assign busy = (st_q != S_IDLE);
  assign cfg_ready_o = (st_q == S_IDLE) && !start;
  always_comb begin
    free_slot = '0;
    free_any = 1'b0;
    for (int i = MaxLines - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        free_slot = SlotW'(i);
        free_any = 1'b1;
      end
    end
  end
  always_comb begin
    st_d = st_q; vld_d = vld_q; old_d = old_q; new_d = new_q; slot_d = slot_q;
    scan_d = scan_q; occ_d = occ_q; cap_d = cap_q; req_d = req_q; hits_d = hits_q;
    line_d = line_q; last_d = last_q; hit_d = hit_q; ok_d = ok_q;
    evict_only_d = evict_only_q; found_d = found_q;
    pct_d = pct_q; strobe_d = 1'b0; div_start = 1'b0;
    tag_we = 1'b0; tag_wa = slot_q; tag_wd = line_q; tag_ra = scan_q;
    nl_we = 1'b0; nl_wa = slot_q; nl_wd = slot_q; nl_ra = slot_q;
    ol_we = 1'b0; ol_wa = slot_q; ol_wd = slot_q; ol_ra = slot_q;
    case (st_q)
      S_IDLE: begin
        if (cfg_valid_i && cfg_ready_o) begin
          cap_d = cfg_data_i;
          st_d = S_SETUP;
          evict_only_d = 1'b1;
        end else if (accept) begin
          evict_only_d = 1'b0;
          ok_d = has_io_i && (req_type_i == ReqRead || req_type_i == ReqWrite)
                 && (sector_count_i != '0);
          hit_d = 1'b1;
          last_d = last_ln;
          line_d = first_ln;
          if (span_m1 >= TagW'(eff_cap)) begin
            hit_d = 1'b0;
            line_d = last_ln - TagW'(eff_cap) + 1'b1;
          end
          st_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (evict_only_q) begin
          if (occ_q > eff_cap) begin
            slot_d = old_q;
            st_d = S_EVR;
          end else begin
            st_d = S_IDLE;
          end
        end else if (!ok_q) begin
          pct_d = '0; hit_d = 1'b0; st_d = S_OUT;
        end else begin
          scan_d = '0; found_d = 1'b0; st_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Read slot scan_q this cycle; compare next cycle in S_CHK.
        tag_ra = scan_q;
        st_d = S_CHK;
      end
      S_CHK: begin
        if (vld_q[scan_q] && tag_rd == line_q) begin
          slot_d = scan_q;
          found_d = 1'b1;
          if (scan_q == new_q) begin
            st_d = S_LNK;
          end else begin
            st_d = S_MOVE;
          end
        end else if (scan_q == SlotW'(MaxLines - 1)) begin
          hit_d = 1'b0;
          if (occ_q >= eff_cap) begin
            slot_d = old_q; st_d = S_EVR;
          end else begin
            st_d = S_INS;
          end
        end else begin
          scan_d = scan_q + 1'b1; st_d = S_SCAN;
        end
      end
      S_MOVE: begin
        nl_ra = slot_q; ol_ra = slot_q; st_d = S_RDL;
      end
      S_RDL: begin
        // Remove slot (not newest) then append at newest end.
        if (slot_q == old_q) begin
          old_d = nl_rd;
        end else begin
          nl_we = 1'b1; nl_wa = ol_rd; nl_wd = nl_rd;
        end
        ol_we = 1'b1; ol_wa = nl_rd;
        ol_wd = ol_rd;
        st_d = S_INS;
        found_d = 1'b1;
      end
      S_EVR: begin
        nl_ra = slot_q; ol_ra = slot_q; st_d = S_EVL;
      end
      S_EVL: begin
        // Evict the oldest slot.
        if (slot_q == new_q) begin
          new_d = ol_rd;
        end else begin
          ol_we = 1'b1; ol_wa = nl_rd; ol_wd = ol_rd;
        end
        old_d = nl_rd;
        vld_d[slot_q] = 1'b0;
        occ_d = occ_q - 1'b1;
        st_d = evict_only_q ? S_SETUP : S_INS;
      end
      S_INS: begin
        if (found_q) begin
          // Append an existing slot as newest.
          nl_we = 1'b1; nl_wa = new_q; nl_wd = slot_q;
          st_d = S_LNK;
        end else if (free_any) begin
          slot_d = free_slot;
          vld_d[free_slot] = 1'b1;
          tag_we = 1'b1; tag_wa = free_slot; tag_wd = line_q;
          if (occ_q == '0) begin
            old_d = free_slot;
          end else begin
            nl_we = 1'b1; nl_wa = new_q; nl_wd = free_slot;
          end
          ol_we = 1'b1; ol_wa = free_slot; ol_wd = new_q;
          new_d = free_slot;
          occ_d = occ_q + 1'b1;
          st_d = S_LNK;
          found_d = 1'b1;
        end else begin
          st_d = S_LNK;
        end
      end
      S_LNK: begin
        // Finish the append for a moved slot, then the next line or, after the last, the divide.
        if (found_q && slot_q != new_q) begin
          ol_we = 1'b1; ol_wa = slot_q; ol_wd = new_q;
          new_d = slot_q;
        end
        if (line_q == last_q) begin
          if (req_q != TotMax) begin
            req_d = req_q + 1'b1;
            if (hit_q) hits_d = hits_q + 1'b1;
          end
          st_d = S_DIV;
          found_d = 1'b0;
        end else begin
          line_d = line_q + 1'b1;
          scan_d = '0; found_d = 1'b0; st_d = S_SCAN;
        end
      end
      S_DIV: begin
        if (!found_q) begin
          div_start = 1'b1; found_d = 1'b1;
        end else if (div_done) begin
          pct_d = div_pct; st_d = S_OUT;
        end
      end
      S_OUT: begin
        strobe_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; vld_q <= '0; old_q <= '0; new_q <= '0; occ_q <= '0;
      cap_q <= CapW'(MaxLines); req_q <= '0; hits_q <= '0; strobe_q <= 1'b0;
      evict_only_q <= 1'b0; found_q <= 1'b0;
    end else begin
      st_q <= st_d; vld_q <= vld_d; old_q <= old_d; new_q <= new_d; occ_q <= occ_d;
      cap_q <= cap_d; req_q <= req_d; hits_q <= hits_d; strobe_q <= strobe_d;
      evict_only_q <= evict_only_d; found_q <= found_d;
    end
  end
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d; scan_q <= scan_d; line_q <= line_d; last_q <= last_d;
    hit_q <= hit_d; ok_q <= ok_d; pct_q <= pct_d;
  end
  assign result_strobe_o = strobe_q;
  assign result_valid_o = strobe_q & ok_q;
  assign hit_o = strobe_q & ok_q & hit_q;
  assign hit_percent_o = strobe_q ? pct_q : '0;

  `LCS_ASSERT(a_occ_cap, clk_i, rst_ni, (occ_q <= CapW'(MaxLines)))
  `LCS_ASSERT(a_hits_le_req, clk_i, rst_ni, (hits_q <= req_q))
  `LCS_ASSERT(a_strobe_idle, clk_i, rst_ni, result_strobe_o |-> (st_q == S_IDLE))
endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the LRU cache hit simulator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  typedef struct packed {
    logic           valid;
    logic           hit;
    logic [PctW-1:0] pct;
  } cache_result_t;

  typedef struct packed {
    logic                has_io;
    logic [1:0]          req_type;
    logic [SectorW-1:0]  start_sector;
    logic [CountW-1:0]   sector_count;
    logic                typed;
    cache_result_t       known;
  } req_row_t;

  localparam int unsigned WatchdogLimit = 400000;
  localparam logic [SectorW-1:0] SectorMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic has_io_i;
  logic [1:0] req_type_i;
  logic [SectorW-1:0] start_sector_i;
  logic [CountW-1:0] sector_count_i;
  logic cfg_valid;
  logic cfg_ready;
  logic [CapW-1:0] cfg_data;
  logic result_strobe;
  logic result_valid_o;
  logic hit_o;
  logic [PctW-1:0] hit_percent_o;

  lru_cache_hit_simulator dut (
    .clk_i, .rst_ni, .start, .busy, .has_io_i, .req_type_i, .start_sector_i,
    .sector_count_i, .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data), .result_strobe_o(result_strobe),
    .result_valid_o, .hit_o, .hit_percent_o
  );

  // Model state: resident lines ordered from least to most recently used.
  logic [TagW-1:0] lru_lines[$];
  logic [CapW-1:0] capacity_reg;
  logic [TotW-1:0] request_total;
  logic [TotW-1:0] hit_total;
  cache_result_t expected_results[$];
  req_row_t known_rows[$];
  int errors;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_capacity(logic [CapW-1:0] cap);
    if (cap == 0) begin
      return 1;
    end
    if (cap > MaxLines) begin
      return MaxLines;
    end
    return cap;
  endfunction

  function automatic cache_result_t lookup_request(logic io, logic [1:0] kind,
                                                   logic [SectorW-1:0] first_sec,
                                                   logic [CountW-1:0] count);
    cache_result_t res;
    logic [SectorW:0] last_sec;
    logic [TagW-1:0] first_line;
    logic [TagW-1:0] last_line;
    logic [TagW-1:0] line;
    logic all_hit;
    int unsigned cap;
    int idx[$];
    res = '0;
    if (!io || (kind != ReqRead && kind != ReqWrite) || count == 0) begin
      return res;
    end
    last_sec = {1'b0, first_sec} + (SectorW+1)'(count) - 1'b1;
    if (last_sec > {1'b0, SectorMax}) begin
      last_sec = {1'b0, SectorMax};
    end
    first_line = first_sec[SectorW-1:OffW];
    last_line = last_sec[SectorW-1:OffW];
    cap = eff_capacity(capacity_reg);
    all_hit = 1'b1;
    if (last_line - first_line + 1 > cap) begin
      all_hit = 1'b0;
      first_line = last_line - TagW'(cap) + 1'b1;
    end
    line = first_line;
    while (1) begin
      idx = lru_lines.find_first_index(t) with (t == line);
      if (idx.size() != 0) begin
        lru_lines.delete(idx[0]);
      end else begin
        all_hit = 1'b0;
        if (lru_lines.size() >= cap) begin
          void'(lru_lines.pop_front());
        end
      end
      lru_lines.push_back(line);
      if (line == last_line) begin
        break;
      end
      line++;
    end
    if (request_total != TotMax) begin
      request_total++;
      if (all_hit) begin
        hit_total++;
      end
    end
    res.valid = 1'b1;
    res.hit = all_hit;
    res.pct = PctW'((64'(hit_total) * 64'd100) / 64'(request_total));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t pred;
    cache_result_t want;
    req_row_t row;
    logic moved;
    if (!rst_ni) begin
      lru_lines.delete();
      capacity_reg = CapW'(MaxLines);
      request_total = '0;
      hit_total = '0;
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity_reg = cfg_data;
        while (lru_lines.size() > eff_capacity(cfg_data)) begin
          void'(lru_lines.pop_front());
        end
        moved = 1'b1;
      end
      if (start && !busy) begin
        pred = lookup_request(has_io_i, req_type_i, start_sector_i, sector_count_i);
        if (known_rows.size() != 0) begin
          row = known_rows.pop_front();
          if (row.typed) begin
            pred = row.known;
          end
        end
        expected_results.push_back(pred);
        moved = 1'b1;
      end
      if (result_strobe) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat valid=%0b hit=%0b pct=%0d", $time,
                   result_valid_o, hit_o, hit_percent_o);
        end else begin
          want = expected_results.pop_front();
          if (want.valid !== result_valid_o) begin
            errors++;
            $display("%0t: result_valid expected %0b actual %0b", $time, want.valid,
                     result_valid_o);
          end
          if (want.hit !== hit_o) begin
            errors++;
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
          end
          if (want.pct !== hit_percent_o) begin
            errors++;
            $display("%0t: hit_percent expected %0d actual %0d", $time, want.pct,
                     hit_percent_o);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    @(posedge clk_i);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(logic io, logic [1:0] kind, logic [SectorW-1:0] sec,
                              logic [CountW-1:0] count);
    logic was_busy;
    start <= 1'b1;
    has_io_i <= io;
    req_type_i <= kind;
    start_sector_i <= sec;
    sector_count_i <= count;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_capacity(logic [CapW-1:0] value);
    logic got_ready;
    drain_results();
    repeat (100) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk_i);
      got_ready = cfg_ready;
      @(posedge clk_i);
    end while (!got_ready);
    cfg_valid <= 1'b0;
    repeat (1100) @(posedge clk_i);
  endtask

  initial begin
    req_row_t directed[$];
    logic [CapW-1:0] phase_caps[10];
    logic [SectorW-1:0] base;
    logic [SectorW-1:0] sec;
    logic [CountW-1:0] count;
    logic io;
    logic [1:0] kind;
    int unsigned window;
    int idle_pct;
    int pick;
    errors = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    has_io_i = 1'b0;
    req_type_i = ReqRead;
    start_sector_i = '0;
    sector_count_i = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      '{1'b0, ReqRead, 48'd0, 20'd1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{1'b1, 2'd2, 48'd0, 20'd1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{1'b1, 2'd3, 48'd0, 20'd1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{1'b1, ReqRead, 48'd0, 20'd0, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{1'b1, ReqRead, 48'd0, 20'd1, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{1'b1, ReqWrite, 48'd7, 20'd1, 1'b1, '{1'b1, 1'b1, 7'd50}},
      '{1'b1, ReqWrite, 48'd0, 20'd16, 1'b0, '0},
      '{1'b1, ReqRead, 48'd0, 20'd16, 1'b0, '0},
      '{1'b1, ReqRead, SectorMax, CountMax, 1'b0, '0},
      '{1'b1, ReqWrite, SectorMax - 48'd3, 20'd2, 1'b0, '0},
      '{1'b1, ReqWrite, 48'd0, CountMax, 1'b0, '0},
      '{1'b1, ReqRead, 48'd1048560, 20'd8, 1'b0, '0},
      '{1'b1, ReqRead, 48'd0, 20'd1, 1'b0, '0},
      '{1'b0, 2'd3, SectorMax, CountMax, 1'b1, '{1'b0, 1'b0, 7'd0}}
    };
    foreach (directed[i]) begin
      known_rows.push_back(directed[i]);
      send_request(directed[i].has_io, directed[i].req_type, directed[i].start_sector,
                   directed[i].sector_count);
    end

    phase_caps = '{9'd1, 9'd0, 9'd4, 9'd16, 9'd64, 9'd511, 9'd256, 9'd8, 9'd2, 9'd32};
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      case (p % 4)
        1: idle_pct = 49;
        3: idle_pct = 29;
        default: idle_pct = 0;
      endcase
      window = eff_capacity(phase_caps[p]) * SectorsPerLine * 2;
      base = SectorW'({$urandom(), $urandom()});
      for (int n = 0; n < 195; n++) begin
        pick = $urandom_range(0, 99);
        io = 1'b1;
        kind = $urandom_range(0, 1) ? ReqWrite : ReqRead;
        sec = base + $urandom_range(0, window);
        count = CountW'($urandom_range(1, 24));
        if (pick < 6) begin
          io = 1'($urandom_range(0, 1));
          kind = 2'($urandom_range(0, 3));
          sec = SectorW'({$urandom(), $urandom()});
          count = CountW'($urandom());
          if (io && (kind == ReqRead || kind == ReqWrite)) begin
            io = 1'b0;
          end
        end else if (pick < 8) begin
          sec = SectorW'({$urandom(), $urandom()});
        end else if (pick < 10) begin
          count = 20'd0;
        end
        send_request(io, kind, sec, count);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
        end
      end
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
